@@ rtl/core/mkdel_pkg.sv @@
package mkdel_pkg;

  localparam int TIME_W   = 32;
  localparam int SCAN_W   = 10;
  localparam int DEB_W    = 16;
  localparam int PIN_BITS = 4;
  localparam int KEY_W    = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [SCAN_W-1:0] SCAN_PERIOD_RESET = SCAN_W'(10);
  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET    = DEB_W'(30);

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_SCAN_PERIOD   = 1'b0,
    REG_DEBOUNCE_TIME = 1'b1
  } reg_idx_t;

  // broadcast to every key lane for one accepted request
  typedef struct packed {
    logic              prime;
    logic              scan;
    logic [TIME_W-1:0] now;
    logic [DEB_W-1:0]  debounce;
  } lane_ctl_t;

endpackage

@@ rtl/core/multi_key_debounce_event_latch_top.sv @@
// The result is registered in the cycle after its request is accepted.
// Throughput: one request per cycle while result_stall is low; a new request is
//   taken in the cycle the previous result leaves.
// Reset: synchronous, clears time, priming and each key's raw, stable and
//   pending state; scan_period returns to 10 and debounce_time to 30.
module multi_key_debounce_event_latch_top #(
  parameter int NUM_KEYS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            operation,
  input  logic [mkdel_pkg::PIN_BITS-1:0]  key_pins,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [mkdel_pkg::PIN_BITS-1:0]  stable_keys,
  output logic                            event_valid,
  output logic [mkdel_pkg::KEY_W-1:0]     event_key,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mkdel_pkg::ADDR_W-1:0]    paddr,
  input  logic [mkdel_pkg::DATA_W-1:0]    pwdata,
  output logic [mkdel_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);

  logic [mkdel_pkg::SCAN_W-1:0] scan_period;
  logic [mkdel_pkg::DEB_W-1:0]  debounce_time;
  logic [mkdel_pkg::TIME_W-1:0] tick_time;
  logic [mkdel_pkg::TIME_W-1:0] last_scan_time;
  logic [mkdel_pkg::TIME_W-1:0] now;
  logic [mkdel_pkg::TIME_W-1:0] since_scan;
  logic                         primed;

  logic                accept;
  logic                is_tick;
  logic                is_take;
  logic                scan_due;
  logic                cfg_wr;
  mkdel_pkg::reg_idx_t cfg_sel;
  mkdel_pkg::lane_ctl_t ctl;

  logic [NUM_KEYS-1:0] stable_vec;
  logic [NUM_KEYS-1:0] pending_vec;
  logic [NUM_KEYS-1:0] grant;
  logic                found;
  logic [mkdel_pkg::KEY_W-1:0] pick_key;
  logic [NUM_KEYS+mkdel_pkg::PIN_BITS-1:0] stable_ext;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_sel = mkdel_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_period   <= mkdel_pkg::SCAN_PERIOD_RESET;
      debounce_time <= mkdel_pkg::DEBOUNCE_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        mkdel_pkg::REG_SCAN_PERIOD:   scan_period   <= pwdata[mkdel_pkg::SCAN_W-1:0];
        mkdel_pkg::REG_DEBOUNCE_TIME: debounce_time <= pwdata[mkdel_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      mkdel_pkg::REG_SCAN_PERIOD:
        prdata = {{(mkdel_pkg::DATA_W-mkdel_pkg::SCAN_W){1'b0}}, scan_period};
      mkdel_pkg::REG_DEBOUNCE_TIME:
        prdata = {{(mkdel_pkg::DATA_W-mkdel_pkg::DEB_W){1'b0}}, debounce_time};
      default:
        prdata = '0;
    endcase
  end

  // request handshake
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign is_tick    = accept && (operation == mkdel_pkg::OP_TICK);
  assign is_take    = accept && (operation == mkdel_pkg::OP_TAKE);

  // time base
  assign now        = tick_time + mkdel_pkg::TIME_W'(1);
  assign since_scan = now - last_scan_time;
  assign scan_due   = since_scan >=
                      {{(mkdel_pkg::TIME_W-mkdel_pkg::SCAN_W){1'b0}}, scan_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_time      <= '0;
      last_scan_time <= '0;
      primed         <= 1'b0;
    end else if (is_tick) begin
      tick_time <= now;
      primed    <= 1'b1;
      if (!primed || scan_due) begin
        last_scan_time <= now;
      end
    end
  end

  assign ctl.prime    = is_tick && !primed;
  assign ctl.scan     = is_tick && primed && scan_due;
  assign ctl.now      = now;
  assign ctl.debounce = debounce_time;

  // key lanes
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic pressed;
    if (k < mkdel_pkg::PIN_BITS) begin : g_pin
      assign pressed = ~key_pins[k];
    end else begin : g_nopin
      assign pressed = 1'b0;
    end

    mkdel_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .pressed    (pressed),
      .take_clear (is_take && grant[k]),
      .stable     (stable_vec[k]),
      .pending    (pending_vec[k])
    );
  end

  mkdel_pick #(
    .NUM_KEYS (NUM_KEYS)
  ) u_pick (
    .pending (pending_vec),
    .grant   (grant),
    .found   (found),
    .key     (pick_key)
  );

  // result register; lane state only moves when the result slot frees,
  // so stable_keys can come straight from the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_valid <= is_take && found;
      event_key   <= (is_take && found) ? pick_key : '0;
    end
  end

  assign stable_ext  = {{mkdel_pkg::PIN_BITS{1'b0}}, stable_vec};
  assign stable_keys = stable_ext[mkdel_pkg::PIN_BITS-1:0];

  a_key_zero_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !event_valid |-> event_key == '0)
    else $error("event_key set without event");

  a_tick_no_event: assert property (@(posedge clk) disable iff (rst)
    is_tick |=> !event_valid)
    else $error("tick produced an event");

  a_take_clears_one: assert property (@(posedge clk) disable iff (rst)
    is_take && found |=> $countones(pending_vec) == $countones($past(pending_vec)) - 1)
    else $error("take did not clear exactly one pending key");

  a_take_empty: assert property (@(posedge clk) disable iff (rst)
    is_take && !found |=> !event_valid && $stable(pending_vec))
    else $error("empty take reported an event");

  a_unprimed_quiet: assert property (@(posedge clk) disable iff (rst)
    !primed |-> pending_vec == '0 && stable_vec == '0)
    else $error("key state set before priming");

endmodule

@@ rtl/core/mkdel_lane.sv @@
module mkdel_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  mkdel_pkg::lane_ctl_t ctl,
  input  logic                 pressed,
  input  logic                 take_clear,
  output logic                 stable,
  output logic                 pending
);

  logic                         raw;
  logic [mkdel_pkg::TIME_W-1:0] change_time;
  logic [mkdel_pkg::TIME_W-1:0] held;

  assign held = ctl.now - change_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw     <= 1'b0;
      stable  <= 1'b0;
      pending <= 1'b0;
    end else if (ctl.prime) begin
      raw     <= pressed;
      stable  <= pressed;
      pending <= 1'b0;
    end else if (ctl.scan) begin
      if (pressed != raw) begin
        raw <= pressed;
      end else if (stable != pressed &&
                   held >= {{(mkdel_pkg::TIME_W-mkdel_pkg::DEB_W){1'b0}}, ctl.debounce}) begin
        stable <= pressed;
        if (pressed) begin
          pending <= 1'b1;
        end
      end
    end else if (take_clear) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prime || (ctl.scan && pressed != raw)) begin
      change_time <= ctl.now;
    end
  end

endmodule

@@ rtl/core/mkdel_pick.sv @@
module mkdel_pick #(
  parameter int NUM_KEYS = 4
) (
  input  logic [NUM_KEYS-1:0] pending,
  output logic [NUM_KEYS-1:0] grant,
  output logic                found,
  output logic [mkdel_pkg::KEY_W-1:0] key
);

  localparam int KEY_IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [KEY_IW-1:0] idx;
  logic [KEY_IW+mkdel_pkg::KEY_W-1:0] idx_ext;

  // lowest set bit
  assign grant = pending & (~pending + NUM_KEYS'(1));
  assign found = |pending;

  always_comb begin
    idx = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (grant[i]) begin
        idx = idx | KEY_IW'(i);
      end
    end
  end

  assign idx_ext = {{mkdel_pkg::KEY_W{1'b0}}, idx};
  assign key     = idx_ext[mkdel_pkg::KEY_W-1:0];

endmodule
